// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SPTFK_ASSERT(lbl, prop) lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
  prop) else $error("assertion failed");
`define SPTFK_ASSERT_ALWAYS(lbl, prop) lbl: assert property (@(posedge clk_i) prop) \
  else $error("assertion failed");
`else
`define SPTFK_ASSERT(lbl, prop)
`define SPTFK_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- hdl/sptfk_pkg.sv -----
// Types, constants and arithmetic helpers of the spin pair table kernel.
package sptfk_pkg;

  localparam int TBL_DEPTH = 1029;
  localparam int TBL_AW = 11;
  localparam logic [TBL_AW-1:0] TBL_DEPTH_A = 11'd1029;
  localparam logic [10:0] RESOLUTION = 11'd1024;
  localparam logic [3:0] MAX_TYPES = 4'd8;

  typedef enum logic [1:0] {OPC_LOAD, OPC_BEGIN, OPC_NEIGH, OPC_FINISH} opcode_e;
  typedef enum logic [1:0] {KIND_NEIGH, KIND_TOTAL, KIND_ERROR} kind_e;
  typedef enum logic [1:0] {REG_CUTOFF, REG_SCALE, REG_PARTNER, REG_RES} reg_e;
  typedef enum logic [2:0] {CMD_LOAD, CMD_BEGIN, CMD_NEIGH, CMD_ERR, CMD_FINISH} cmd_kind_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [10:0]        table_addr;
    logic signed [31:0] energy_word;
    logic signed [31:0] slope_word;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    logic signed [31:0] spin_x;
    logic signed [31:0] spin_y;
    logic signed [31:0] spin_z;
    logic [2:0]         neighbor_type;
    logic [15:0]        atom_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [15:0]        target_index;
    logic signed [47:0] field_x;
    logic signed [47:0] field_y;
    logic signed [47:0] field_z;
    logic signed [47:0] force_x;
    logic signed [47:0] force_y;
    logic signed [47:0] force_z;
    logic signed [47:0] energy;
  } out_item_t;

  // Command passed from the front to the back. addr is the load address,
  // or the table index m for a neighbor.
  typedef struct packed {
    cmd_kind_e          kind;
    logic [TBL_AW-1:0]  addr;
    logic [15:0]        t;
    logic [31:0]        ewd;
    logic [31:0]        swd;
    logic [2:0][31:0]   d;
    logic [2:0][31:0]   s;
    logic [15:0]        idx;
  } cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sh7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (x < -64'sh8000_0000) r = -32'sh8000_0000;
    else r = 32'(x);
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] x);
    logic signed [47:0] r;
    if (x > 64'sh7FFF_FFFF_FFFF) r = 48'sh7FFF_FFFF_FFFF;
    else if (x < -64'sh8000_0000_0000) r = -48'sh8000_0000_0000;
    else r = 48'(x);
    return r;
  endfunction

  // Leading cubic coefficient: 3(p1-p2)+p3-p0
  function automatic logic signed [39:0] cub_c3(input logic signed [31:0] p0,
      input logic signed [31:0] p1, input logic signed [31:0] p2,
      input logic signed [31:0] p3);
    logic signed [39:0] r;
    r = 40'sd3 * (40'(p1) - 40'(p2)) + 40'(p3) - 40'(p0);
    return r;
  endfunction

  // 2p0-5p1+4p2-p3
  function automatic logic signed [39:0] cub_c2(input logic signed [31:0] p0,
      input logic signed [31:0] p1, input logic signed [31:0] p2,
      input logic signed [31:0] p3);
    logic signed [39:0] r;
    r = 40'sd2 * 40'(p0) - 40'sd5 * 40'(p1) + 40'sd4 * 40'(p2) - 40'(p3);
    return r;
  endfunction

endpackage

// ----- hdl/sptfk_ram.sv -----
// Generic single write port RAM with registered read.
module sptfk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ----- hdl/sptfk_cmd_queue.sv -----
// Two-entry command queue between the front and the back.
`include "assert_macros.svh"
module sptfk_cmd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  sptfk_pkg::cmd_t   cmd_i,
  output logic              full_o,
  input  logic              rd_i,
  output logic              empty_o,
  output sptfk_pkg::cmd_t   cmd_o
);
  sptfk_pkg::cmd_t ent_q [2];
  logic            wptr_q, rptr_q;
  logic [1:0]      cnt_q;
  logic            do_wr, do_rd;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign cmd_o   = ent_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      ent_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_wr) wptr_q <= ~wptr_q;
      if (do_rd) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(do_wr) - 2'(do_rd);
    end
  end

  `SPTFK_ASSERT(a_cnt_range, cnt_q != 2'd3)
  `SPTFK_ASSERT(a_cnt_step, (do_wr && !do_rd) |=> (cnt_q == $past(cnt_q) + 2'd1))
  `SPTFK_ASSERT(a_ptr_gap, (cnt_q == 2'd1) |-> (wptr_q != rptr_q))
endmodule

// ----- hdl/sptfk_front.sv -----
// Front end: register port, item intake, type and cutoff filter, table index.
`include "assert_macros.svh"
module sptfk_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel_i,
  input  logic                 penable_i,
  input  logic                 pwrite_i,
  input  logic [3:0]           paddr_i,
  input  logic [31:0]          pwdata_i,
  output logic [31:0]          prdata_o,
  input  logic                 push_i,
  output logic                 full_o,
  input  sptfk_pkg::in_item_t  item_i,
  output logic                 cmd_push_o,
  output sptfk_pkg::cmd_t      cmd_o,
  input  logic                 cmd_full_i
);
  typedef enum logic [2:0] {F_IDLE, F_SQ0, F_SQ1, F_SQ2, F_CMP, F_POS, F_CLS, F_PUSH} fstate_e;

  fstate_e         state_q;
  sptfk_pkg::cmd_t cmd_q;
  logic [31:0]     cutoff_q, scale_q;
  logic [3:0]      partner_q;
  logic [10:0]     res_q;
  logic [63:0]     sq_q, sum_q, pos_q;
  logic [31:0]     rsq_q;
  logic            cfg_wr, accept, type_ok;
  logic signed [31:0] dsel;
  logic signed [63:0] sq_prod;
  logic [63:0]     total, pos_prod;
  logic [10:0]     bound;
  logic [31:0]     m_val;
  logic            m_err;

  assign cfg_wr = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q  <= '0;
      scale_q   <= '0;
      partner_q <= sptfk_pkg::MAX_TYPES;
      res_q     <= sptfk_pkg::RESOLUTION;
    end else if (cfg_wr) begin
      unique case (sptfk_pkg::reg_e'(paddr_i[3:2]))
        sptfk_pkg::REG_CUTOFF:  cutoff_q  <= pwdata_i;
        sptfk_pkg::REG_SCALE:   scale_q   <= pwdata_i;
        sptfk_pkg::REG_PARTNER: partner_q <= pwdata_i[3:0];
        sptfk_pkg::REG_RES:     res_q     <= pwdata_i[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sptfk_pkg::reg_e'(paddr_i[3:2]))
      sptfk_pkg::REG_CUTOFF:  prdata_o = cutoff_q;
      sptfk_pkg::REG_SCALE:   prdata_o = scale_q;
      sptfk_pkg::REG_PARTNER: prdata_o = {28'd0, partner_q};
      sptfk_pkg::REG_RES:     prdata_o = {21'd0, res_q};
      default:                prdata_o = '0;
    endcase
  end

  assign full_o  = (state_q != F_IDLE);
  assign accept  = push_i && !full_o;
  assign type_ok = (partner_q == sptfk_pkg::MAX_TYPES) ||
                   (partner_q == {1'b0, item_i.neighbor_type});

  always_comb begin
    unique case (state_q)
      F_SQ0:   dsel = $signed(cmd_q.d[0]);
      F_SQ1:   dsel = $signed(cmd_q.d[1]);
      default: dsel = $signed(cmd_q.d[2]);
    endcase
  end
  assign sq_prod  = dsel * dsel;
  assign total    = sum_q + sq_q;
  assign pos_prod = {32'd0, rsq_q} * {32'd0, scale_q};
  assign bound    = (res_q < sptfk_pkg::RESOLUTION) ? res_q : sptfk_pkg::RESOLUTION;
  assign m_val    = pos_q[63:32];
  assign m_err    = (m_val == 32'd0) || (m_val > {21'd0, bound});

  assign cmd_push_o = (state_q == F_PUSH);
  assign cmd_o      = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cmd_q   <= '0;
      sq_q    <= '0;
      sum_q   <= '0;
      pos_q   <= '0;
      rsq_q   <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (accept) begin
            cmd_q.addr <= item_i.table_addr;
            cmd_q.t    <= '0;
            cmd_q.ewd  <= item_i.energy_word;
            cmd_q.swd  <= item_i.slope_word;
            cmd_q.d    <= {item_i.dz, item_i.dy, item_i.dx};
            cmd_q.s    <= {item_i.spin_z, item_i.spin_y, item_i.spin_x};
            cmd_q.idx  <= item_i.atom_index;
            unique case (sptfk_pkg::opcode_e'(item_i.opcode))
              sptfk_pkg::OPC_LOAD: begin
                cmd_q.kind <= sptfk_pkg::CMD_LOAD;
                if (item_i.table_addr < sptfk_pkg::TBL_DEPTH_A) state_q <= F_PUSH;
              end
              sptfk_pkg::OPC_BEGIN: begin
                cmd_q.kind <= sptfk_pkg::CMD_BEGIN;
                state_q    <= F_PUSH;
              end
              sptfk_pkg::OPC_NEIGH: begin
                cmd_q.kind <= sptfk_pkg::CMD_NEIGH;
                if (type_ok) state_q <= F_SQ0;
              end
              sptfk_pkg::OPC_FINISH: begin
                cmd_q.kind <= sptfk_pkg::CMD_FINISH;
                state_q    <= F_PUSH;
              end
              default: ;
            endcase
          end
        end
        F_SQ0: begin
          sq_q    <= 64'(sq_prod);
          sum_q   <= '0;
          state_q <= F_SQ1;
        end
        F_SQ1: begin
          sum_q   <= total;
          sq_q    <= 64'(sq_prod);
          state_q <= F_SQ2;
        end
        F_SQ2: begin
          sum_q   <= total;
          sq_q    <= 64'(sq_prod);
          state_q <= F_CMP;
        end
        F_CMP: begin
          rsq_q <= total[47:16];
          if (total[63:16] > {16'd0, cutoff_q}) state_q <= F_IDLE;
          else state_q <= F_POS;
        end
        F_POS: begin
          pos_q   <= pos_prod;
          state_q <= F_CLS;
        end
        F_CLS: begin
          // m is at most 1024 when it passes the bound check
          cmd_q.addr <= m_val[10:0];
          cmd_q.t    <= pos_q[31:16];
          cmd_q.kind <= m_err ? sptfk_pkg::CMD_ERR : sptfk_pkg::CMD_NEIGH;
          state_q    <= F_PUSH;
        end
        F_PUSH: begin
          if (!cmd_full_i) state_q <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  `SPTFK_ASSERT(a_neigh_index, (cmd_push_o && cmd_q.kind == sptfk_pkg::CMD_NEIGH) |->
                (cmd_q.addr != 11'd0 && cmd_q.addr <= sptfk_pkg::RESOLUTION))
  `SPTFK_ASSERT(a_load_addr, (cmd_push_o && cmd_q.kind == sptfk_pkg::CMD_LOAD) |->
                (cmd_q.addr < sptfk_pkg::TBL_DEPTH_A))
  `SPTFK_ASSERT(a_push_hold, (cmd_push_o && cmd_full_i) |=> cmd_push_o)
endmodule

// ----- hdl/sptfk_back.sv -----
// Back end: table memories, cubic interpolation, spin products, accumulators.
`include "assert_macros.svh"
module sptfk_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_empty_i,
  input  sptfk_pkg::cmd_t       cmd_i,
  output logic                  cmd_pop_o,
  output logic                  empty_o,
  input  logic                  pop_i,
  output sptfk_pkg::out_item_t  result_o
);
  typedef enum logic [2:0] {B_IDLE, B_READ, B_PREP, B_MUL, B_ACC, B_EMIT} bstate_e;
  typedef enum logic [4:0] {
    OP_E0, OP_E1, OP_E2, OP_S0, OP_S1, OP_S2, OP_D0, OP_D1, OP_D2, OP_DS,
    OP_N0, OP_N1, OP_N2, OP_C0, OP_C1, OP_C2, OP_F0, OP_F1, OP_F2, OP_EN
  } op_e;

  bstate_e            state_q;
  op_e                op_q;
  logic [2:0]         rcnt_q;
  sptfk_pkg::cmd_t    cmd_q;
  logic signed [31:0] pe_q [4];
  logic signed [31:0] ps_q [4];
  logic signed [39:0] acc_q, sp_q;
  logic signed [31:0] e_q, de_q, ds_q;
  logic signed [72:0] prod_q;
  logic signed [31:0] cs_q [3];
  logic [15:0]        cidx_q;
  logic signed [47:0] fsum_q [3];
  logic signed [47:0] gsum_q [3];
  logic signed [47:0] esum_q;
  sptfk_pkg::out_item_t res_q, out_q;
  logic               out_valid_q;

  logic               we;
  logic [sptfk_pkg::TBL_AW-1:0] raddr;
  logic [31:0]        rd_e, rd_s;
  logic [1:0]         ridx;
  logic               is_e, emit_ok;
  logic signed [31:0] c0, c1, c2, c3, dot;
  logic signed [39:0] ma;
  logic signed [32:0] mb, tt;
  logic signed [72:0] sh16, sh17, sh30;

  assign cmd_pop_o = (state_q == B_IDLE) && !cmd_empty_i;
  assign we        = cmd_pop_o && (cmd_i.kind == sptfk_pkg::CMD_LOAD);
  assign raddr     = cmd_q.addr + {9'd0, rcnt_q[1:0]} - 11'd1;
  assign ridx      = rcnt_q[1:0] - 2'd1;

  sptfk_ram #(.WIDTH(32), .DEPTH(sptfk_pkg::TBL_DEPTH)) u_energy_ram (
    .clk_i, .we_i(we), .waddr_i(cmd_i.addr), .wdata_i(cmd_i.ewd),
    .raddr_i(raddr), .rdata_o(rd_e)
  );
  sptfk_ram #(.WIDTH(32), .DEPTH(sptfk_pkg::TBL_DEPTH)) u_slope_ram (
    .clk_i, .we_i(we), .waddr_i(cmd_i.addr), .wdata_i(cmd_i.swd),
    .raddr_i(raddr), .rdata_o(rd_s)
  );

  assign is_e = (op_q == OP_E0) || (op_q == OP_E1) || (op_q == OP_E2);
  assign c0   = is_e ? pe_q[0] : ps_q[0];
  assign c1   = is_e ? pe_q[1] : ps_q[1];
  assign c2   = is_e ? pe_q[2] : ps_q[2];
  assign c3   = is_e ? pe_q[3] : ps_q[3];
  assign dot  = sptfk_pkg::sat32(64'(sp_q));
  assign tt   = $signed({17'd0, cmd_q.t});
  assign sh16 = prod_q >>> 16;
  assign sh17 = prod_q >>> 17;
  assign sh30 = prod_q >>> 30;

  // Operand select of the shared multiplier
  always_comb begin
    unique case (op_q)
      OP_E0, OP_E1, OP_E2, OP_S0, OP_S1, OP_S2: begin ma = acc_q; mb = tt; end
      OP_D0: begin ma = 40'(cs_q[0]); mb = 33'($signed(cmd_q.s[0])); end
      OP_D1: begin ma = 40'(cs_q[1]); mb = 33'($signed(cmd_q.s[1])); end
      OP_D2: begin ma = 40'(cs_q[2]); mb = 33'($signed(cmd_q.s[2])); end
      OP_DS: begin ma = 40'(de_q); mb = 33'(dot); end
      OP_N0: begin ma = 40'(e_q); mb = 33'(cs_q[0]); end
      OP_N1: begin ma = 40'(e_q); mb = 33'(cs_q[1]); end
      OP_N2: begin ma = 40'(e_q); mb = 33'(cs_q[2]); end
      OP_C0: begin ma = 40'(e_q); mb = 33'($signed(cmd_q.s[0])); end
      OP_C1: begin ma = 40'(e_q); mb = 33'($signed(cmd_q.s[1])); end
      OP_C2: begin ma = 40'(e_q); mb = 33'($signed(cmd_q.s[2])); end
      OP_F0: begin ma = 40'(ds_q); mb = 33'($signed(cmd_q.d[0])); end
      OP_F1: begin ma = 40'(ds_q); mb = 33'($signed(cmd_q.d[1])); end
      OP_F2: begin ma = 40'(ds_q); mb = 33'($signed(cmd_q.d[2])); end
      OP_EN: begin ma = 40'(e_q); mb = 33'(dot); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign emit_ok  = !out_valid_q || pop_i;
  assign empty_o  = !out_valid_q;
  assign result_o = out_q;

  always_ff @(posedge clk_i) begin
    if (state_q == B_MUL) prod_q <= 73'(ma * mb);
    if (state_q == B_EMIT && emit_ok) out_q <= res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      op_q        <= OP_E0;
      rcnt_q      <= '0;
      cmd_q       <= '0;
      out_valid_q <= 1'b0;
      cidx_q      <= '0;
      esum_q      <= '0;
      acc_q       <= '0;
      sp_q        <= '0;
      e_q         <= '0;
      de_q        <= '0;
      ds_q        <= '0;
      res_q       <= '0;
      for (int k = 0; k < 4; k++) begin
        pe_q[k] <= '0;
        ps_q[k] <= '0;
      end
      for (int k = 0; k < 3; k++) begin
        cs_q[k]   <= '0;
        fsum_q[k] <= '0;
        gsum_q[k] <= '0;
      end
    end else begin
      if (state_q == B_EMIT && emit_ok) out_valid_q <= 1'b1;
      else if (pop_i) out_valid_q <= 1'b0;

      unique case (state_q)
        B_IDLE: begin
          if (cmd_pop_o) begin
            cmd_q <= cmd_i;
            unique case (cmd_i.kind)
              sptfk_pkg::CMD_BEGIN: begin
                for (int k = 0; k < 3; k++) begin
                  cs_q[k]   <= $signed(cmd_i.s[k]);
                  fsum_q[k] <= '0;
                  gsum_q[k] <= '0;
                end
                esum_q <= '0;
                cidx_q <= cmd_i.idx;
              end
              sptfk_pkg::CMD_NEIGH: begin
                rcnt_q  <= '0;
                res_q   <= '{result_kind: sptfk_pkg::KIND_NEIGH, target_index: cmd_i.idx,
                             default: '0};
                state_q <= B_READ;
              end
              sptfk_pkg::CMD_ERR: begin
                res_q   <= '{result_kind: sptfk_pkg::KIND_ERROR, target_index: cmd_i.idx,
                             default: '0};
                state_q <= B_EMIT;
              end
              sptfk_pkg::CMD_FINISH: begin
                res_q.result_kind  <= sptfk_pkg::KIND_TOTAL;
                res_q.target_index <= cidx_q;
                res_q.field_x      <= fsum_q[0];
                res_q.field_y      <= fsum_q[1];
                res_q.field_z      <= fsum_q[2];
                res_q.force_x      <= gsum_q[0];
                res_q.force_y      <= gsum_q[1];
                res_q.force_z      <= gsum_q[2];
                res_q.energy       <= esum_q;
                state_q            <= B_EMIT;
              end
              default: ;  // loads go straight to the memories
            endcase
          end
        end
        B_READ: begin
          // address issued at count c returns at count c+1
          if (rcnt_q != 3'd0) begin
            pe_q[ridx] <= $signed(rd_e);
            ps_q[ridx] <= $signed(rd_s);
          end
          if (rcnt_q == 3'd4) state_q <= B_PREP;
          else rcnt_q <= rcnt_q + 3'd1;
        end
        B_PREP: begin
          if (pe_q[1] == 32'sd0) begin
            state_q <= B_IDLE;
          end else begin
            acc_q   <= sptfk_pkg::cub_c3(pe_q[0], pe_q[1], pe_q[2], pe_q[3]);
            op_q    <= OP_E0;
            state_q <= B_MUL;
          end
        end
        B_MUL: state_q <= B_ACC;
        B_ACC: begin
          unique case (op_q)
            OP_E0, OP_S0: acc_q <= 40'(sh16) + sptfk_pkg::cub_c2(c0, c1, c2, c3);
            OP_E1, OP_S1: acc_q <= 40'(sh16) + (40'(c2) - 40'(c0));
            OP_E2: begin
              e_q   <= sptfk_pkg::sat32(64'(c1) + 64'(sh17));
              acc_q <= sptfk_pkg::cub_c3(ps_q[0], ps_q[1], ps_q[2], ps_q[3]);
            end
            OP_S2: de_q <= sptfk_pkg::sat32(64'(c1) + 64'(sh17));
            OP_D0: sp_q <= 40'(sh30);
            OP_D1, OP_D2: sp_q <= sp_q + 40'(sh30);
            OP_DS: ds_q <= sptfk_pkg::sat32(64'(sh30));
            OP_N0: res_q.field_x <= 48'(sh30);
            OP_N1: res_q.field_y <= 48'(sh30);
            OP_N2: res_q.field_z <= 48'(sh30);
            OP_C0: fsum_q[0] <= sptfk_pkg::sat48(64'(fsum_q[0]) + 64'(sh30));
            OP_C1: fsum_q[1] <= sptfk_pkg::sat48(64'(fsum_q[1]) + 64'(sh30));
            OP_C2: fsum_q[2] <= sptfk_pkg::sat48(64'(fsum_q[2]) + 64'(sh30));
            OP_F0: begin
              res_q.force_x <= 48'(sh16);
              gsum_q[0] <= sptfk_pkg::sat48(64'(gsum_q[0]) - 64'(sh16));
            end
            OP_F1: begin
              res_q.force_y <= 48'(sh16);
              gsum_q[1] <= sptfk_pkg::sat48(64'(gsum_q[1]) - 64'(sh16));
            end
            OP_F2: begin
              res_q.force_z <= 48'(sh16);
              gsum_q[2] <= sptfk_pkg::sat48(64'(gsum_q[2]) - 64'(sh16));
            end
            OP_EN: esum_q <= sptfk_pkg::sat48(64'(esum_q) + 64'(sh30));
            default: ;
          endcase
          if (op_q == OP_EN) begin
            state_q <= B_EMIT;
          end else begin
            op_q    <= op_e'(op_q + 5'd1);
            state_q <= B_MUL;
          end
        end
        B_EMIT: begin
          if (emit_ok) state_q <= B_IDLE;
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  `SPTFK_ASSERT(a_read_cnt, (state_q == B_READ) |-> (rcnt_q <= 3'd4))
  `SPTFK_ASSERT(a_esum_src, !$stable(esum_q) |->
                ($past(state_q) == B_ACC || $past(state_q) == B_IDLE))
  `SPTFK_ASSERT(a_emit_loads, (state_q == B_EMIT && emit_ok) |=> !empty_o)
endmodule

// ----- hdl/spin_pair_table_force_kernel.sv -----
// Top level of the spin pair table kernel.
// Items enter through a queue-style port and results leave through another;
// registers are written over the APB port at byte addresses 0, 4, 8 and 12.
// Load, begin and finish items go from intake straight to hand-off. A neighbor
// passes the front through intake, three squares, cutoff compare, index multiply,
// classify and hand-off, and the back through taking the command, the table reads,
// set-up, 20 products through one shared multiplier (each a multiply and an
// accumulate step) and the result hand-over; the back sets the sustained neighbor
// rate. A two-entry command queue lets the front classify the next item while the
// back computes, and the result register lets the back go on while a finished
// result waits for its transfer.
`include "assert_macros.svh"
module spin_pair_table_force_kernel (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  sptfk_pkg::in_item_t   item_i,
  output logic                  empty,
  input  logic                  pop,
  output sptfk_pkg::out_item_t  result_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  sptfk_pkg::cmd_t f_cmd, q_cmd;
  logic            f_push, q_full, q_empty, b_pop;

  assign pready = 1'b1;

  sptfk_front u_front (
    .clk_i, .rst_ni,
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .prdata_o(prdata),
    .push_i(push), .full_o(full), .item_i,
    .cmd_push_o(f_push), .cmd_o(f_cmd), .cmd_full_i(q_full)
  );

  sptfk_cmd_queue u_queue (
    .clk_i, .rst_ni,
    .wr_i(f_push), .cmd_i(f_cmd), .full_o(q_full),
    .rd_i(b_pop), .empty_o(q_empty), .cmd_o(q_cmd)
  );

  sptfk_back u_back (
    .clk_i, .rst_ni,
    .cmd_empty_i(q_empty), .cmd_i(q_cmd), .cmd_pop_o(b_pop),
    .empty_o(empty), .pop_i(pop), .result_o
  );
endmodule
